>>> src/tbq_pkg.sv
`timescale 1ns / 1ps
package tbq_pkg;

    localparam int DW = 16;
    localparam int FB = DW - 2;
    localparam int TW = FB + 1;
    localparam int RW = 15;
    localparam int AW = 3;
    localparam int PW = 32;

    localparam logic [RW-1:0] RADIUS_RESET = 15'd13107;
    localparam logic REG_BALL_RADIUS = 1'b0;

    localparam int N_SQL = 16;
    localparam int N_DVL = 16;
    localparam int N_CTX = 3 + N_SQL + N_DVL;
    localparam int N_SQN = 32;
    localparam int N_SQD = 17;
    localparam int N_DVT = 15;
    localparam int N_TL  = N_SQN + 3;
    localparam int N_SQW = 15;
    localparam int N_DVR = 15;
    localparam int N_FN  = N_SQW + 1;
    localparam int N_STG = N_CTX + 5 + N_SQN + 1 + N_SQW + 1;

    typedef logic signed [DW-1:0] coord_t;

    localparam coord_t ONE = coord_t'(2 ** FB);
    localparam logic [TW-1:0] T_ONE = TW'(2 ** FB);

    typedef struct packed {
        coord_t          x1;
        coord_t          y1;
        coord_t          x2;
        coord_t          y2;
        logic [RW-1:0]   r;
        logic [2*RW-1:0] r2;
        logic [1:0]      in_ball;
        logic            eq;
    } ctx_t;

    typedef struct packed {
        logic [RW-1:0]   r;
        logic [2*RW-1:0] r2;
        logic            eq;
    } rad_t;

    typedef struct packed {
        logic [2:0][30:0] ms;
        logic [2:0]       sg;
        logic             tsat;
        logic             ident;
        logic [RW-1:0]    r;
        logic [33:0]      dist2;
    } tl_t;

    typedef struct packed {
        logic [2:0] sg;
        logic       ident;
    } fn_t;

endpackage

>>> src/tbq_if.sv
`timescale 1ns / 1ps
interface tbq_drag_if;
    import tbq_pkg::*;

    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;

    modport source
    (
        output valid, start_x, start_y, end_x, end_y,
        input  ready
    );

    modport sink
    (
        input  valid, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

interface tbq_quat_if;
    import tbq_pkg::*;

    logic   valid;
    logic   ready;
    coord_t rot_x;
    coord_t rot_y;
    coord_t rot_z;
    coord_t rot_w;

    modport source
    (
        output valid, rot_x, rot_y, rot_z, rot_w,
        input  ready
    );

    modport sink
    (
        input  valid, rot_x, rot_y, rot_z, rot_w,
        output ready
    );
endinterface

>>> src/tbq_apb_regs.sv
`timescale 1ns / 1ps
module tbq_apb_regs
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [tbq_pkg::AW-1:0]  paddr,
    input  logic [tbq_pkg::PW-1:0]  pwdata,
    output logic [tbq_pkg::PW-1:0]  prdata,
    output logic                    pready,
    output logic [tbq_pkg::RW-1:0]  radius
);
    import tbq_pkg::*;

    logic [RW-1:0] radius_reg;
    logic [RW-1:0] radius_next;
    logic          sel_radius;

    assign pready     = 1'b1;
    assign sel_radius = (paddr[AW-1] == REG_BALL_RADIUS);
    assign radius     = radius_reg;

    always_comb
    begin
        radius_next = radius_reg;
        if (psel && penable && pwrite && sel_radius)
        begin
            radius_next = pwdata[RW-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_radius)
        begin
            prdata = {{(PW-RW){1'b0}}, radius_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else
        begin
            radius_reg <= radius_next;
        end
    end
endmodule

>>> src/trackball_drag_to_quaternion_top.sv
`timescale 1ns / 1ps
// virtual trackball: one drag (start point, end point) in, one rotation quaternion out
// drag channel: start_x, start_y, end_x, end_y, signed Q2.14, taken when valid and ready
// quat channel: rot_x, rot_y, rot_z (vector part), rot_w (scalar part), signed Q2.14
// config port: apb-style, ball_radius at byte address 0 (15 bits, Q1.14), pready tied high
// throughput: one drag per cycle while quat is not stalling, set by the 89-stage pipeline; the
// long poles are the bit-per-stage square roots and restoring dividers (lift, axis norm, angle)
// all stages advance together; drag ready is low only while the output word is
// held and quat ready is low, and then the whole pipeline freezes with nothing lost
// reset clears every valid bit and sets ball_radius to 0.8
// the radius must only be written while no drag is in flight
module trackball_drag_to_quaternion_top
(
    input  logic                    clk,
    input  logic                    rst_n,
    tbq_drag_if.sink                drag,
    tbq_quat_if.source              quat,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [tbq_pkg::AW-1:0]  paddr,
    input  logic [tbq_pkg::PW-1:0]  pwdata,
    output logic [tbq_pkg::PW-1:0]  prdata,
    output logic                    pready
);
    import tbq_pkg::*;

    logic [RW-1:0]    radius;
    logic             en;
    logic [N_STG-1:0] vld_reg;
    logic [N_STG-1:0] vld_next;

    ctx_t        ctx_reg [N_CTX];
    ctx_t        ctx_next [N_CTX];
    logic [30:0] sq_reg [4];
    logic [30:0] sq_next [4];
    logic [31:0] d2_c [2];
    logic [31:0] op_c [2];
    logic [1:0]  inside_c;

    logic [31:0] sl_v_reg [N_SQL+1][2];
    logic [31:0] sl_v_next [N_SQL+1][2];
    logic [31:0] sl_r_reg [N_SQL+1][2];
    logic [31:0] sl_r_next [N_SQL+1][2];

    logic [31:0] dl_rem_reg [N_DVL][2];
    logic [31:0] dl_rem_next [N_DVL][2];
    logic [16:0] dl_den_reg [N_DVL][2];
    logic [16:0] dl_den_next [N_DVL][2];
    logic [15:0] dl_q_reg [N_DVL][2];
    logic [15:0] dl_q_next [N_DVL][2];
    logic [15:0] dl_root_reg [N_DVL][2];
    logic [15:0] dl_root_next [N_DVL][2];

    logic signed [32:0] xp_reg [6];
    logic signed [32:0] xp_next [6];
    logic signed [16:0] dd_reg [3];
    logic signed [16:0] dd_next [3];
    rad_t               c2_reg [2];
    rad_t               c2_next [2];

    logic [31:0] m_reg [3];
    logic [31:0] m_next [3];
    logic [2:0]  sg_reg;
    logic [2:0]  sg_next;
    logic [31:0] ds_reg [3];
    logic [31:0] ds_next [3];

    tl_t         tl_reg [N_TL];
    tl_t         tl_next [N_TL];
    logic [61:0] msq_reg [3];
    logic [61:0] msq_next [3];

    logic [63:0] sn_v_reg [N_SQN+1];
    logic [63:0] sn_v_next [N_SQN+1];
    logic [63:0] sn_r_reg [N_SQN+1];
    logic [63:0] sn_r_next [N_SQN+1];
    logic [33:0] sd_v_reg [N_SQD+1];
    logic [33:0] sd_v_next [N_SQD+1];
    logic [33:0] sd_r_reg [N_SQD+1];
    logic [33:0] sd_r_next [N_SQD+1];

    logic [31:0]   dt_rem_reg [N_DVT];
    logic [31:0]   dt_rem_next [N_DVT];
    logic [RW:0]   dt_den_reg [N_DVT];
    logic [RW:0]   dt_den_next [N_DVT];
    logic [TW-1:0] dt_q_reg [N_DVT];
    logic [TW-1:0] dt_q_next [N_DVT];

    logic [45:0] pm_reg [3];
    logic [45:0] pm_next [3];
    logic [31:0] n_reg;
    logic [31:0] n_next;
    fn_t         fn_reg [N_FN];
    fn_t         fn_next [N_FN];

    logic [29:0] sw_op_c;
    logic [29:0] sw_v_reg [N_SQW+1];
    logic [29:0] sw_v_next [N_SQW+1];
    logic [29:0] sw_r_reg [N_SQW+1];
    logic [29:0] sw_r_next [N_SQW+1];

    logic [45:0]   dr_rem_reg [N_DVR][3];
    logic [45:0]   dr_rem_next [N_DVR][3];
    logic [TW-1:0] dr_q_reg [N_DVR][3];
    logic [TW-1:0] dr_q_next [N_DVR][3];
    logic [31:0]   dr_n_reg [N_DVR];
    logic [31:0]   dr_n_next [N_DVR];

    coord_t out_reg [4];
    coord_t out_next [4];

    tbq_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .radius  (radius)
    );

    assign en         = !vld_reg[N_STG-1] || quat.ready;
    assign drag.ready = en;
    assign vld_next   = {vld_reg[N_STG-2:0], drag.valid};

    assign quat.valid = vld_reg[N_STG-1];
    assign quat.rot_x = out_reg[0];
    assign quat.rot_y = out_reg[1];
    assign quat.rot_z = out_reg[2];
    assign quat.rot_w = out_reg[3];

    // capture, radius squared, lift select
    always_comb
    begin
        ctx_next[0].x1      = drag.start_x;
        ctx_next[0].y1      = drag.start_y;
        ctx_next[0].x2      = drag.end_x;
        ctx_next[0].y2      = drag.end_y;
        ctx_next[0].r       = radius;
        ctx_next[0].r2      = '0;
        ctx_next[0].in_ball = '0;
        ctx_next[0].eq      = (drag.start_x == drag.end_x) && (drag.start_y == drag.end_y);
        ctx_next[1]         = ctx_reg[0];
        ctx_next[1].r2      = ctx_reg[0].r * ctx_reg[0].r;
        ctx_next[2]         = ctx_reg[1];
        ctx_next[2].in_ball = inside_c;
        for (int i = 3; i < N_CTX; i++)
        begin
            ctx_next[i] = ctx_reg[i-1];
        end
    end

    always_comb
    begin
        logic signed [2*DW-1:0] sqp [4];
        sqp[0] = ctx_reg[0].x1 * ctx_reg[0].x1;
        sqp[1] = ctx_reg[0].y1 * ctx_reg[0].y1;
        sqp[2] = ctx_reg[0].x2 * ctx_reg[0].x2;
        sqp[3] = ctx_reg[0].y2 * ctx_reg[0].y2;
        for (int i = 0; i < 4; i++)
        begin
            sq_next[i] = sqp[i][30:0];
        end
    end

    always_comb
    begin
        logic [31:0] r2x;
        r2x = {2'b00, ctx_reg[1].r2};
        for (int p = 0; p < 2; p++)
        begin
            d2_c[p]     = {1'b0, sq_reg[2*p]} + {1'b0, sq_reg[2*p+1]};
            inside_c[p] = (d2_c[p] < r2x) && ((r2x - d2_c[p]) > d2_c[p]);
            op_c[p]     = inside_c[p] ? (r2x - d2_c[p]) : d2_c[p];
        end
    end

    // lift square root, one result bit per stage
    always_comb
    begin
        logic [31:0] bitv;
        logic [32:0] sum;
        for (int p = 0; p < 2; p++)
        begin
            sl_v_next[0][p] = op_c[p];
            sl_r_next[0][p] = '0;
        end
        for (int j = 1; j <= N_SQL; j++)
        begin
            for (int p = 0; p < 2; p++)
            begin
                bitv = 32'(1) << (30 - 2 * (j - 1));
                sum  = {1'b0, sl_r_reg[j-1][p]} + {1'b0, bitv};
                if ({1'b0, sl_v_reg[j-1][p]} >= sum)
                begin
                    sl_v_next[j][p] = sl_v_reg[j-1][p] - sum[31:0];
                    sl_r_next[j][p] = (sl_r_reg[j-1][p] >> 1) + bitv;
                end
                else
                begin
                    sl_v_next[j][p] = sl_v_reg[j-1][p];
                    sl_r_next[j][p] = sl_r_reg[j-1][p] >> 1;
                end
            end
        end
    end

    // hyperbola divide, rounded r*r / (2d)
    always_comb
    begin
        logic [31:0] rem_in;
        logic [16:0] den_in;
        logic [15:0] q_in;
        logic [15:0] root_in;
        logic [32:0] trial;
        for (int k = 0; k < N_DVL; k++)
        begin
            for (int p = 0; p < 2; p++)
            begin
                if (k == 0)
                begin
                    root_in = sl_r_reg[N_SQL][p][15:0];
                    rem_in  = {2'b00, ctx_reg[N_SQL+2].r2} + {16'b0, root_in};
                    den_in  = {root_in, 1'b0};
                    q_in    = '0;
                end
                else
                begin
                    root_in = dl_root_reg[k-1][p];
                    rem_in  = dl_rem_reg[k-1][p];
                    den_in  = dl_den_reg[k-1][p];
                    q_in    = dl_q_reg[k-1][p];
                end
                trial                = 33'(den_in) << (N_DVL - 1 - k);
                dl_root_next[k][p]   = root_in;
                dl_den_next[k][p]    = den_in;
                if ({1'b0, rem_in} >= trial)
                begin
                    dl_rem_next[k][p] = rem_in - trial[31:0];
                    dl_q_next[k][p]   = q_in | (16'(1) << (N_DVL - 1 - k));
                end
                else
                begin
                    dl_rem_next[k][p] = rem_in;
                    dl_q_next[k][p]   = q_in;
                end
            end
        end
    end

    // lift result, cross terms and point differences
    always_comb
    begin
        logic [15:0]        z_c [2];
        logic signed [16:0] zs [2];
        ctx_t               c;
        c = ctx_reg[N_CTX-1];
        for (int p = 0; p < 2; p++)
        begin
            if (c.in_ball[p])
            begin
                z_c[p] = dl_root_reg[N_DVL-1][p];
            end
            else if (dl_root_reg[N_DVL-1][p] == '0)
            begin
                z_c[p] = '0;
            end
            else
            begin
                z_c[p] = dl_q_reg[N_DVL-1][p];
            end
            zs[p] = {1'b0, z_c[p]};
        end
        xp_next[0] = c.y2 * zs[0];
        xp_next[1] = zs[1] * c.y1;
        xp_next[2] = zs[1] * c.x1;
        xp_next[3] = c.x2 * zs[0];
        xp_next[4] = c.x2 * c.y1;
        xp_next[5] = c.y2 * c.x1;
        dd_next[0] = {c.x1[DW-1], c.x1} - {c.x2[DW-1], c.x2};
        dd_next[1] = {c.y1[DW-1], c.y1} - {c.y2[DW-1], c.y2};
        dd_next[2] = zs[0] - zs[1];
        c2_next[0] = '{r: c.r, r2: c.r2, eq: c.eq};
        c2_next[1] = c2_reg[0];
    end

    // axis components, magnitudes, squared distances
    always_comb
    begin
        logic signed [33:0] av;
        logic [33:0]        mg;
        logic signed [33:0] dsq;
        for (int i = 0; i < 3; i++)
        begin
            av         = {xp_reg[2*i][32], xp_reg[2*i]} - {xp_reg[2*i+1][32], xp_reg[2*i+1]};
            sg_next[i] = av[33];
            mg         = av[33] ? (34'(0) - av) : av;
            m_next[i]  = mg[31:0];
            dsq        = dd_reg[i] * dd_reg[i];
            ds_next[i] = dsq[31:0];
        end
    end

    // normalize axis magnitudes, total distance, special cases
    always_comb
    begin
        logic shft;
        shft = m_reg[0][31] | m_reg[1][31] | m_reg[2][31];
        for (int i = 0; i < 3; i++)
        begin
            tl_next[0].ms[i] = shft ? m_reg[i][31:1] : m_reg[i][30:0];
            tl_next[0].sg[i] = sg_reg[i];
        end
        tl_next[0].dist2 = 34'(ds_reg[0]) + 34'(ds_reg[1]) + 34'(ds_reg[2]);
        tl_next[0].tsat  = tl_next[0].dist2 >= {2'b00, c2_reg[1].r2, 2'b00};
        tl_next[0].ident = c2_reg[1].eq
                           || ((m_reg[0] == '0) && (m_reg[1] == '0) && (m_reg[2] == '0));
        tl_next[0].r     = c2_reg[1].r;
        for (int i = 1; i < N_TL; i++)
        begin
            tl_next[i] = tl_reg[i-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            msq_next[i] = tl_reg[0].ms[i] * tl_reg[0].ms[i];
        end
    end

    // axis norm square root
    always_comb
    begin
        logic [63:0] bitv;
        logic [64:0] sum;
        sn_v_next[0] = 64'(msq_reg[0]) + 64'(msq_reg[1]) + 64'(msq_reg[2]);
        sn_r_next[0] = '0;
        for (int j = 1; j <= N_SQN; j++)
        begin
            bitv = 64'(1) << (62 - 2 * (j - 1));
            sum  = {1'b0, sn_r_reg[j-1]} + {1'b0, bitv};
            if ({1'b0, sn_v_reg[j-1]} >= sum)
            begin
                sn_v_next[j] = sn_v_reg[j-1] - sum[63:0];
                sn_r_next[j] = (sn_r_reg[j-1] >> 1) + bitv;
            end
            else
            begin
                sn_v_next[j] = sn_v_reg[j-1];
                sn_r_next[j] = sn_r_reg[j-1] >> 1;
            end
        end
    end

    // drag length square root
    always_comb
    begin
        logic [33:0] bitv;
        logic [34:0] sum;
        sd_v_next[0] = tl_reg[1].dist2;
        sd_r_next[0] = '0;
        for (int j = 1; j <= N_SQD; j++)
        begin
            bitv = 34'(1) << (32 - 2 * (j - 1));
            sum  = {1'b0, sd_r_reg[j-1]} + {1'b0, bitv};
            if ({1'b0, sd_v_reg[j-1]} >= sum)
            begin
                sd_v_next[j] = sd_v_reg[j-1] - sum[33:0];
                sd_r_next[j] = (sd_r_reg[j-1] >> 1) + bitv;
            end
            else
            begin
                sd_v_next[j] = sd_v_reg[j-1];
                sd_r_next[j] = sd_r_reg[j-1] >> 1;
            end
        end
    end

    // half-angle sine divide, rounded length / (2r)
    always_comb
    begin
        logic [31:0]   rem_in;
        logic [RW:0]   den_in;
        logic [TW-1:0] q_in;
        logic [32:0]   trial;
        for (int k = 0; k < N_DVT; k++)
        begin
            if (k == 0)
            begin
                rem_in = {sd_r_reg[N_SQD][17:0], {FB{1'b0}}}
                         + 32'(tl_reg[N_SQD+2].r);
                den_in = {tl_reg[N_SQD+2].r, 1'b0};
                q_in   = '0;
            end
            else
            begin
                rem_in = dt_rem_reg[k-1];
                den_in = dt_den_reg[k-1];
                q_in   = dt_q_reg[k-1];
            end
            trial          = 33'(den_in) << (N_DVT - 1 - k);
            dt_den_next[k] = den_in;
            if ({1'b0, rem_in} >= trial)
            begin
                dt_rem_next[k] = rem_in - trial[31:0];
                dt_q_next[k]   = q_in | (TW'(1) << (N_DVT - 1 - k));
            end
            else
            begin
                dt_rem_next[k] = rem_in;
                dt_q_next[k]   = q_in;
            end
        end
    end

    // clamp sine, scale axis, cosine operand
    always_comb
    begin
        logic [TW-1:0]   t;
        logic [2*TW-1:0] tt;
        tl_t             c;
        c = tl_reg[N_TL-1];
        if (c.tsat || (dt_q_reg[N_DVT-1] > T_ONE))
        begin
            t = T_ONE;
        end
        else
        begin
            t = dt_q_reg[N_DVT-1];
        end
        for (int i = 0; i < 3; i++)
        begin
            pm_next[i] = c.ms[i] * t;
        end
        tt         = t * t;
        sw_op_c    = (30'(1) << (2 * FB)) - tt;
        n_next     = sn_r_reg[N_SQN][31:0];
        fn_next[0] = '{sg: c.sg, ident: c.ident};
        for (int i = 1; i < N_FN; i++)
        begin
            fn_next[i] = fn_reg[i-1];
        end
    end

    // cosine square root
    always_comb
    begin
        logic [29:0] bitv;
        logic [30:0] sum;
        sw_v_next[0] = sw_op_c;
        sw_r_next[0] = '0;
        for (int j = 1; j <= N_SQW; j++)
        begin
            bitv = 30'(1) << (2 * FB - 2 * (j - 1));
            sum  = {1'b0, sw_r_reg[j-1]} + {1'b0, bitv};
            if ({1'b0, sw_v_reg[j-1]} >= sum)
            begin
                sw_v_next[j] = sw_v_reg[j-1] - sum[29:0];
                sw_r_next[j] = (sw_r_reg[j-1] >> 1) + bitv;
            end
            else
            begin
                sw_v_next[j] = sw_v_reg[j-1];
                sw_r_next[j] = sw_r_reg[j-1] >> 1;
            end
        end
    end

    // axis normalize divide, rounded |a| * t / n
    always_comb
    begin
        logic [45:0]   rem_in;
        logic [31:0]   den_in;
        logic [TW-1:0] q_in;
        logic [46:0]   trial;
        for (int k = 0; k < N_DVR; k++)
        begin
            den_in       = (k == 0) ? n_reg : dr_n_reg[k-1];
            dr_n_next[k] = den_in;
            trial        = 47'(den_in) << (N_DVR - 1 - k);
            for (int i = 0; i < 3; i++)
            begin
                if (k == 0)
                begin
                    rem_in = pm_reg[i] + 46'(n_reg >> 1);
                    q_in   = '0;
                end
                else
                begin
                    rem_in = dr_rem_reg[k-1][i];
                    q_in   = dr_q_reg[k-1][i];
                end
                if ({1'b0, rem_in} >= trial)
                begin
                    dr_rem_next[k][i] = rem_in - trial[45:0];
                    dr_q_next[k][i]   = q_in | (TW'(1) << (N_DVR - 1 - k));
                end
                else
                begin
                    dr_rem_next[k][i] = rem_in;
                    dr_q_next[k][i]   = q_in;
                end
            end
        end
    end

    // output word
    always_comb
    begin
        coord_t qv;
        fn_t    f;
        f = fn_reg[N_FN-1];
        for (int i = 0; i < 3; i++)
        begin
            qv = coord_t'(dr_q_reg[N_DVR-1][i]);
            if (f.ident)
            begin
                out_next[i] = '0;
            end
            else
            begin
                out_next[i] = f.sg[i] ? (coord_t'(0) - qv) : qv;
            end
        end
        out_next[3] = f.ident ? ONE : coord_t'(sw_r_reg[N_SQW][DW-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg     <= ctx_next;
            sq_reg      <= sq_next;
            sl_v_reg    <= sl_v_next;
            sl_r_reg    <= sl_r_next;
            dl_rem_reg  <= dl_rem_next;
            dl_den_reg  <= dl_den_next;
            dl_q_reg    <= dl_q_next;
            dl_root_reg <= dl_root_next;
            xp_reg      <= xp_next;
            dd_reg      <= dd_next;
            c2_reg      <= c2_next;
            m_reg       <= m_next;
            sg_reg      <= sg_next;
            ds_reg      <= ds_next;
            tl_reg      <= tl_next;
            msq_reg     <= msq_next;
            sn_v_reg    <= sn_v_next;
            sn_r_reg    <= sn_r_next;
            sd_v_reg    <= sd_v_next;
            sd_r_reg    <= sd_r_next;
            dt_rem_reg  <= dt_rem_next;
            dt_den_reg  <= dt_den_next;
            dt_q_reg    <= dt_q_next;
            pm_reg      <= pm_next;
            n_reg       <= n_next;
            fn_reg      <= fn_next;
            sw_v_reg    <= sw_v_next;
            sw_r_reg    <= sw_r_next;
            dr_rem_reg  <= dr_rem_next;
            dr_q_reg    <= dr_q_next;
            dr_n_reg    <= dr_n_next;
            out_reg     <= out_next;
        end
    end

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        drag.valid && drag.ready |=> vld_reg[0])
        else $error("accepted drag word did not enter the pipeline");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_vec_range: assert property (@(posedge clk) disable iff (!rst_n)
        quat.valid |-> (quat.rot_x <= ONE) && (quat.rot_x >= -ONE)
                       && (quat.rot_y <= ONE) && (quat.rot_y >= -ONE)
                       && (quat.rot_z <= ONE) && (quat.rot_z >= -ONE))
        else $error("vector part out of unit range");

    a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
        quat.valid |-> (quat.rot_w >= 0) && (quat.rot_w <= ONE))
        else $error("scalar part out of unit range");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import tbq_pkg::*;

    typedef struct {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
    } drag_t;

    typedef struct {
        coord_t qx;
        coord_t qy;
        coord_t qz;
        coord_t qw;
    } quat_t;

    class quat_scoreboard;
        quat_t            pending_q[$];
        logic [RW-1:0]    radius;
        int               errors;
        int               n_checked;

        function new();
            radius = RADIUS_RESET;
            errors = 0;
            n_checked = 0;
        endfunction

        function automatic bit [63:0] isqrt(bit [63:0] v);
            bit [63:0] res;
            bit [63:0] b;
            res = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        function automatic bit [63:0] magn(longint v);
            return (v < 0) ? bit'(0) - 64'(v) : 64'(v);
        endfunction

        function automatic bit [63:0] sat_sum(bit [63:0] a, bit [63:0] b);
            return (a > 64'hFFFF_FFFF_FFFF_FFFF - b) ? 64'hFFFF_FFFF_FFFF_FFFF : a + b;
        endfunction

        function automatic longint lift_z(bit [63:0] r, longint x, longint y);
            bit [63:0] mx;
            bit [63:0] my;
            bit [63:0] d2;
            bit [63:0] r2;
            bit [63:0] d;
            mx = magn(x);
            my = magn(y);
            d2 = mx * mx + my * my;
            r2 = r * r;
            if (d2 < r2 && r2 - d2 > d2)
                return longint'(isqrt(r2 - d2));
            d = isqrt(d2);
            if (d == 0)
                return 0;
            return longint'((r2 + d) / (2 * d));
        endfunction

        function automatic quat_t rotation_of(drag_t dg);
            quat_t q;
            longint x1;
            longint y1;
            longint x2;
            longint y2;
            longint z1;
            longint z2;
            longint a[3];
            bit [63:0] m[3];
            bit [63:0] mx;
            bit [63:0] r;
            bit [63:0] n;
            bit [63:0] dist2;
            bit [63:0] t;
            bit [63:0] w;
            bit [63:0] v;
            bit [63:0] one;
            int s;
            one = 64'd1 << FB;
            x1 = dg.sx;
            y1 = dg.sy;
            x2 = dg.ex;
            y2 = dg.ey;
            q.qx = 0;
            q.qy = 0;
            q.qz = 0;
            q.qw = ONE;
            if (x1 == x2 && y1 == y2)
                return q;
            r = radius;
            z1 = lift_z(r, x1, y1);
            z2 = lift_z(r, x2, y2);
            a[0] = y2 * z1 - z2 * y1;
            a[1] = z2 * x1 - x2 * z1;
            a[2] = x2 * y1 - y2 * x1;
            if (a[0] == 0 && a[1] == 0 && a[2] == 0)
                return q;
            mx = 0;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = magn(a[i]);
                if (m[i] > mx)
                    mx = m[i];
            end
            s = 0;
            while ((mx >> s) >= (64'd1 << 31))
                s++;
            for (int i = 0; i < 3; i++)
                m[i] >>= s;
            n = isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
            dist2 = sat_sum(sat_sum(magn(x1 - x2) * magn(x1 - x2),
                                    magn(y1 - y2) * magn(y1 - y2)),
                            magn(z1 - z2) * magn(z1 - z2));
            if (dist2 >= 4 * r * r)
                t = one;
            else
            begin
                t = ((isqrt(dist2) << FB) + r) / (2 * r);
                if (t > one)
                    t = one;
            end
            w = isqrt((one << FB) - t * t);
            for (int i = 0; i < 3; i++)
            begin
                v = (m[i] * t + n / 2) / n;
                if (a[i] < 0)
                    v = 64'd0 - v;
                if (i == 0)
                    q.qx = coord_t'(v);
                else if (i == 1)
                    q.qy = coord_t'(v);
                else
                    q.qz = coord_t'(v);
            end
            q.qw = coord_t'(w);
            return q;
        endfunction

        function void note_drag(drag_t dg);
            pending_q.push_back(rotation_of(dg));
        endfunction

        function void check_quat(quat_t got);
            quat_t want;
            if (pending_q.size() == 0)
            begin
                $display("%0t: quat word with nothing expected: %0d %0d %0d %0d",
                         $time, got.qx, got.qy, got.qz, got.qw);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            if (got.qx !== want.qx)
            begin
                $display("%0t: rot_x expected %0d actual %0d", $time, want.qx, got.qx);
                errors++;
            end
            if (got.qy !== want.qy)
            begin
                $display("%0t: rot_y expected %0d actual %0d", $time, want.qy, got.qy);
                errors++;
            end
            if (got.qz !== want.qz)
            begin
                $display("%0t: rot_z expected %0d actual %0d", $time, want.qz, got.qz);
                errors++;
            end
            if (got.qw !== want.qw)
            begin
                $display("%0t: rot_w expected %0d actual %0d", $time, want.qw, got.qw);
                errors++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [AW-1:0]  paddr;
    logic [PW-1:0]  pwdata;
    logic [PW-1:0]  prdata;
    logic           pready;

    tbq_drag_if drag_ch();
    tbq_quat_if quat_ch();

    trackball_drag_to_quaternion_top uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .drag    (drag_ch),
        .quat    (quat_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    quat_scoreboard sb;
    int n_drags;
    int idle_cycles;
    int burst_left;
    int n_radii;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && drag_ch.valid && drag_ch.ready)
        begin
            sb.note_drag('{drag_ch.start_x, drag_ch.start_y, drag_ch.end_x, drag_ch.end_y});
            n_drags++;
        end
        if (rst_n && quat_ch.valid && quat_ch.ready)
            sb.check_quat('{quat_ch.rot_x, quat_ch.rot_y, quat_ch.rot_z, quat_ch.rot_w});
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((drag_ch.valid && drag_ch.ready) || (quat_ch.valid && quat_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 3000)
        begin
            $display("%0t: timeout, %0d words still expected", $time, sb.pending_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stall pattern, one long hold-off while the pipeline fills
    initial
    begin
        bit held;
        int mode;
        held = 0;
        mode = 0;
        quat_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && n_drags >= 200)
            begin
                held = 1;
                quat_ch.ready = 1'b0;
                repeat (400) @(negedge clk);
            end
            if (($time / 10) % 97 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: quat_ch.ready = 1'b1;
                1: quat_ch.ready = ($urandom_range(0, 1) == 0);
                2: quat_ch.ready = ($urandom_range(0, 3) == 0);
                default: quat_ch.ready = ((($time / 10) % 8) < 5);
            endcase
        end
    end

    task automatic send_drag(drag_t dg);
        if (burst_left == 0)
        begin
            drag_ch.valid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        drag_ch.valid = 1'b1;
        drag_ch.start_x = dg.sx;
        drag_ch.start_y = dg.sy;
        drag_ch.end_x = dg.ex;
        drag_ch.end_y = dg.ey;
        @(posedge clk);
        while (!drag_ch.ready)
            @(posedge clk);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic drain();
        drag_ch.valid = 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic apb_write(logic [AW-1:0] addr, logic [PW-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (addr == 0)
            sb.radius = data[RW-1:0];
    endtask

    task automatic apb_check_radius();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata !== PW'(sb.radius))
        begin
            $display("%0t: ball_radius read expected %0d actual %0d", $time, sb.radius, prdata);
            sb.errors++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    function automatic coord_t rand_coord();
        if ($urandom_range(0, 9) == 0)
            return coord_t'($urandom);
        return coord_t'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic drag_t rand_drag();
        drag_t dg;
        int k;
        dg = '{rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        k = $urandom_range(0, 19);
        if (k == 0)
        begin
            dg.ex = dg.sx;
            dg.ey = dg.sy;
        end
        else if (k < 4)
        begin
            // short drags near the start point
            dg.ex = dg.sx + coord_t'(int'($urandom_range(0, 64)) - 32);
            dg.ey = dg.sy + coord_t'(int'($urandom_range(0, 64)) - 32);
        end
        else if (k == 4)
        begin
            // points on one line through the center
            dg.ex = -dg.sx;
            dg.ey = -dg.sy;
        end
        return dg;
    endfunction

    task automatic run_directed();
        drag_t dir_q[$];
        dir_q = '{
            '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
            '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384},
            '{16'sd0, 16'sd0, 16'sd16384, 16'sd0},
            '{16'sd0, 16'sd0, 16'sd0, -16'sd16384},
            '{-16'sd16384, -16'sd16384, 16'sd16384, 16'sd16384},
            '{16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384},
            '{16'sd4000, 16'sd0, -16'sd4000, 16'sd0},
            '{16'sd2000, 16'sd3000, 16'sd4000, 16'sd6000},
            '{16'sd100, 16'sd0, 16'sd101, 16'sd0},
            '{16'sd9000, 16'sd0, 16'sd9300, 16'sd0},
            '{16'sd0, 16'sd1, 16'sd1, 16'sd0},
            '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767},
            '{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767},
            '{16'sd12000, 16'sd12000, -16'sd12000, 16'sd11999},
            '{-16'sd5, 16'sd7, 16'sd16384, -16'sd16384},
            '{16'sd9267, 16'sd0, 16'sd0, 16'sd9267}
        };
        foreach (dir_q[i])
            send_drag(dir_q[i]);
    endtask

    initial
    begin
        logic [RW-1:0] radii[6];
        sb = new();
        n_drags = 0;
        idle_cycles = 0;
        burst_left = 0;
        n_radii = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        drag_ch.valid = 1'b0;
        drag_ch.start_x = '0;
        drag_ch.start_y = '0;
        drag_ch.end_x = '0;
        drag_ch.end_y = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        radii[0] = RADIUS_RESET;
        radii[1] = 15'd1;
        radii[2] = 15'd32767;
        radii[3] = 15'd16384;
        radii[4] = 15'($urandom_range(1, 32767));
        radii[5] = 15'($urandom_range(1, 2000));
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                apb_write(3'd4, $urandom);
                apb_write(3'd0, {17'($urandom), radii[ph]});
            end
            apb_check_radius();
            n_radii++;
            run_directed();
            repeat (130)
                send_drag(rand_drag());
        end
        // back to the default radius at the end
        drain();
        apb_write(3'd0, PW'(RADIUS_RESET));
        apb_check_radius();
        repeat (40)
            send_drag(rand_drag());
        drain();
        $display("drags: %0d, quaternions checked: %0d, radius settings: %0d",
                 n_drags, sb.n_checked, n_radii + 1);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> filelist.f
src/tbq_pkg.sv
src/tbq_if.sv
src/tbq_apb_regs.sv
src/trackball_drag_to_quaternion_top.sv
tb/tb.sv
